// ----- rtl/core/lslt_pkg.sv -----
package lslt_pkg;

	localparam int TABLE_ENTRIES = 3;
	localparam int SLOT_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int USED_W = $clog2(TABLE_ENTRIES + 1);

	localparam int ADDR_W = 32;
	localparam int COUNT_W = 16;
	localparam int TIME_W = 32;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W = 1;

	localparam logic [COUNT_W-1:0] ERROR_LIMIT_RST = 16'd10;
	localparam logic [TIME_W-1:0] LOCKOUT_SECONDS_RST = 32'd900;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	typedef enum logic {
		CMD_CHECK  = 1'b0,
		CMD_RECORD = 1'b1
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ERROR_LIMIT     = 1'b0,
		REG_LOCKOUT_SECONDS = 1'b1
	} cfg_reg_t;

	// write strobes for one table slot
	typedef struct packed {
		logic ins;  // fresh entry from a check miss
		logic rec;  // outcome record on the front entry
	} slot_wr_t;

	// lookup status from one table slot
	typedef struct packed {
		logic hit;
		logic lock;
	} slot_stat_t;

endpackage

// ----- rtl/core/lslt_slot.sv -----
module lslt_slot (
	input  logic                         clk,
	input  logic                         slot_valid,
	input  logic [lslt_pkg::ADDR_W-1:0]  addr,
	input  logic [lslt_pkg::TIME_W-1:0]  now,
	input  logic                         failed,
	input  logic [lslt_pkg::COUNT_W-1:0] error_limit,
	input  logic [lslt_pkg::TIME_W-1:0]  lockout_seconds,
	input  lslt_pkg::slot_wr_t           wr,
	output lslt_pkg::slot_stat_t         stat
);

	logic [lslt_pkg::ADDR_W-1:0]  addr_q;
	logic [lslt_pkg::COUNT_W-1:0] count_q;
	logic [lslt_pkg::TIME_W-1:0]  time_q;
	logic [lslt_pkg::TIME_W-1:0]  elapsed;

	// wraps mod 2^32 on purpose
	assign elapsed = now - time_q;

	assign stat.hit  = slot_valid && (addr_q == addr);
	assign stat.lock = (count_q >= error_limit) && (elapsed <= lockout_seconds);

	always_ff @(posedge clk) begin
		if (wr.ins) begin
			addr_q  <= addr;
			count_q <= '0;
			time_q  <= now;
		end else if (wr.rec) begin
			if (!failed) begin
				count_q <= '0;
			end else if (count_q != lslt_pkg::COUNT_MAX) begin
				count_q <= count_q + 1'b1;
			end
			time_q <= now;
		end
	end

endmodule

// ----- rtl/core/lslt_recency.sv -----
module lslt_recency (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                go,
	input  lslt_pkg::cmd_t                      cmd,
	input  logic [lslt_pkg::TABLE_ENTRIES-1:0]  slot_hit,
	output logic [lslt_pkg::TABLE_ENTRIES-1:0]  slot_valid,
	output lslt_pkg::slot_wr_t                  wr [lslt_pkg::TABLE_ENTRIES]
);

	logic [lslt_pkg::SLOT_W-1:0] rank_q [lslt_pkg::TABLE_ENTRIES];
	logic [lslt_pkg::SLOT_W-1:0] rank_d [lslt_pkg::TABLE_ENTRIES];
	logic [lslt_pkg::USED_W-1:0] used_q;

	logic                        hit_any;
	logic                        full;
	logic                        is_check;
	logic                        is_rec;
	logic [lslt_pkg::SLOT_W-1:0] hit_pos;
	logic [lslt_pkg::SLOT_W-1:0] hit_slot;
	logic [lslt_pkg::SLOT_W-1:0] mv_pos;
	logic [lslt_pkg::SLOT_W-1:0] mv_slot;

	assign hit_any  = |slot_hit;
	assign full     = (int'(used_q) == lslt_pkg::TABLE_ENTRIES);
	assign is_check = go && (cmd == lslt_pkg::CMD_CHECK);
	assign is_rec   = go && (cmd == lslt_pkg::CMD_RECORD) && (used_q != '0);

	// ranks always form a permutation, so at most one position matches
	always_comb begin
		hit_pos  = '0;
		hit_slot = '0;
		for (int p = 0; p < lslt_pkg::TABLE_ENTRIES; p++) begin
			if (slot_hit[rank_q[p]]) begin
				hit_pos = lslt_pkg::SLOT_W'(p);
			end
			if (slot_hit[p]) begin
				hit_slot = lslt_pkg::SLOT_W'(p);
			end
		end
	end

	// position that moves to the front, and the slot it carries
	always_comb begin
		if (hit_any) begin
			mv_pos  = hit_pos;
			mv_slot = hit_slot;
		end else if (!full) begin
			mv_pos  = used_q[lslt_pkg::SLOT_W-1:0];
			mv_slot = used_q[lslt_pkg::SLOT_W-1:0];
		end else begin
			mv_pos  = lslt_pkg::SLOT_W'(lslt_pkg::TABLE_ENTRIES - 1);
			mv_slot = rank_q[lslt_pkg::TABLE_ENTRIES-1];
		end
	end

	always_comb begin
		for (int i = 0; i < lslt_pkg::TABLE_ENTRIES; i++) begin
			if (i == 0) begin
				rank_d[i] = mv_slot;
			end else if (i <= int'(mv_pos)) begin
				rank_d[i] = rank_q[i-1];
			end else begin
				rank_d[i] = rank_q[i];
			end
		end
	end

	always_comb begin
		for (int s = 0; s < lslt_pkg::TABLE_ENTRIES; s++) begin
			slot_valid[s] = (int'(used_q) > s);
			wr[s].ins     = is_check && !hit_any && (int'(mv_slot) == s);
			wr[s].rec     = is_rec && (int'(rank_q[0]) == s);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < lslt_pkg::TABLE_ENTRIES; i++) begin
				rank_q[i] <= lslt_pkg::SLOT_W'(i);
			end
			used_q <= '0;
		end else if (is_check) begin
			rank_q <= rank_d;
			if (!hit_any && !full) begin
				used_q <= used_q + 1'b1;
			end
		end
	end

endmodule

// ----- rtl/core/lru_source_lockout_table_core.sv -----
// Source lockout table with least-recently-used replacement. Each request
// either checks a 32-bit source address (cmd = 0) or records the outcome of
// the last attempt on the most recent entry (cmd = 1). A check that hits moves
// the entry to the front and answers locked_out = 1 when its failure count is
// at or above error_limit and (now_seconds - its time stamp) mod 2^32 is at
// most lockout_seconds; a miss installs a fresh entry at the front, evicting
// the least recent one once all TABLE_ENTRIES slots are in use, and answers 0.
// A record raises the count (saturating at 65535) or clears it, stamps the
// time, and answers 0; on an empty table it is ignored. Every request yields
// exactly one response. Throughput is one request per clock while
// out_ready is high: a request is registered on acceptance, resolved in
// the input stage by the parallel per-slot address compares and the
// recency-list update, and its response sits in the output register.
// The input side keeps accepting while a response waits, until both the
// input stage and the output register are full. Configuration writes
// must only happen while no request is outstanding.
module lru_source_lockout_table_core (
	input  logic                            clk,
	input  logic                            arst_n,

	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            cmd,
	input  logic [lslt_pkg::ADDR_W-1:0]     source_addr,
	input  logic                            failed,
	input  logic [lslt_pkg::TIME_W-1:0]     now_seconds,

	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            locked_out,

	input  logic                            cfg_we,
	input  logic [lslt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lslt_pkg::CFG_DATA_W-1:0] cfg_data
);

	// input stage
	logic                        valid_s1;
	lslt_pkg::cmd_t              cmd_s1;
	logic [lslt_pkg::ADDR_W-1:0] addr_s1;
	logic                        failed_s1;
	logic [lslt_pkg::TIME_W-1:0] now_s1;

	// response register
	logic out_valid_q;
	logic locked_q;

	// config registers
	logic [lslt_pkg::COUNT_W-1:0] error_limit_q;
	logic [lslt_pkg::TIME_W-1:0]  lockout_seconds_q;

	logic                                 advance;
	logic                                 lock_now;
	logic [lslt_pkg::TABLE_ENTRIES-1:0]   slot_hit;
	logic [lslt_pkg::TABLE_ENTRIES-1:0]   slot_lock;
	logic [lslt_pkg::TABLE_ENTRIES-1:0]   slot_valid;
	lslt_pkg::slot_wr_t                   slot_wr   [lslt_pkg::TABLE_ENTRIES];
	lslt_pkg::slot_stat_t                 slot_stat [lslt_pkg::TABLE_ENTRIES];

	// stage 1 resolves when the response register is free or draining
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	assign out_valid  = out_valid_q;
	assign locked_out = locked_q;

	always_comb begin
		for (int s = 0; s < lslt_pkg::TABLE_ENTRIES; s++) begin
			slot_hit[s]  = slot_stat[s].hit;
			slot_lock[s] = slot_stat[s].lock;
		end
	end

	// records always answer not locked; a miss has no hit bit set
	assign lock_now = (cmd_s1 == lslt_pkg::CMD_CHECK) && |(slot_hit & slot_lock);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1    <= lslt_pkg::cmd_t'(cmd);
			addr_s1   <= source_addr;
			failed_s1 <= failed;
			now_s1    <= now_seconds;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			locked_q <= lock_now;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_limit_q     <= lslt_pkg::ERROR_LIMIT_RST;
			lockout_seconds_q <= lslt_pkg::LOCKOUT_SECONDS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				lslt_pkg::REG_ERROR_LIMIT: begin
					error_limit_q <= cfg_data[lslt_pkg::COUNT_W-1:0];
				end
				lslt_pkg::REG_LOCKOUT_SECONDS: begin
					lockout_seconds_q <= cfg_data[lslt_pkg::TIME_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// recency order, fill count and per-slot write strobes
	lslt_recency u_recency (
		.clk        (clk),
		.arst_n     (arst_n),
		.go         (advance),
		.cmd        (cmd_s1),
		.slot_hit   (slot_hit),
		.slot_valid (slot_valid),
		.wr         (slot_wr)
	);

	// one entry per slot: storage, address compare, lockout test
	for (genvar s = 0; s < lslt_pkg::TABLE_ENTRIES; s++) begin : g_slot
		lslt_slot u_slot (
			.clk             (clk),
			.slot_valid      (slot_valid[s]),
			.addr            (addr_s1),
			.now             (now_s1),
			.failed          (failed_s1),
			.error_limit     (error_limit_q),
			.lockout_seconds (lockout_seconds_q),
			.wr              (slot_wr[s]),
			.stat            (slot_stat[s])
		);
	end

endmodule

// ----- rtl/core/lslt_checker.sv -----
module lslt_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic                            cmd,
	input logic [lslt_pkg::ADDR_W-1:0]     source_addr,
	input logic                            failed,
	input logic [lslt_pkg::TIME_W-1:0]     now_seconds,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic                            locked_out,
	input logic                            cfg_we,
	input logic [lslt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input logic [lslt_pkg::CFG_DATA_W-1:0] cfg_data
);

	// a stalled response holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(locked_out))
		else $error("response changed while stalled");

	// input only backs up when both the input stage and response are stuck
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("in_ready low without output backpressure");

	// a response out of an empty pipe comes from a request that went through the input stage
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("response without a request two cycles earlier");

	// a full, stalled pipe keeps its response valid
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready && !in_ready |=> out_valid)
		else $error("response dropped while pipe full");

endmodule

bind lru_source_lockout_table_core lslt_checker u_lslt_checker (.*);

// ----- sim/lockout_checker.sv -----
`timescale 1ns / 100ps

// Watches both channels and the register port, keeps its own copy of the
// lockout table and compares every response against it in order.
module lockout_checker
	import lslt_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  logic                  cmd,
	input  logic [ADDR_W-1:0]     source_addr,
	input  logic                  failed,
	input  logic [TIME_W-1:0]     now_seconds,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  logic                  locked_out,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    mismatches,
	output int                    pending,
	output int                    locked_seen
);

	logic [COUNT_W-1:0] limit_q;
	logic [TIME_W-1:0]  window_q;
	logic [ADDR_W-1:0]  slot_addr  [TABLE_ENTRIES];
	logic [COUNT_W-1:0] slot_count [TABLE_ENTRIES];
	logic [TIME_W-1:0]  slot_stamp [TABLE_ENTRIES];
	int unsigned        mru        [TABLE_ENTRIES];
	int unsigned        used;
	logic               expected_lock [$];
	int                 requests;
	int                 responses;

	assign pending = requests - responses;

	// rank pos goes to the front, the ranks ahead of it shift back by one
	function automatic void promote(int unsigned pos);
		int unsigned slot;
		slot = mru[pos];
		for (int unsigned p = pos; p > 0; p--)
			mru[p] = mru[p - 1];
		mru[0] = slot;
	endfunction

	function automatic logic predict_lockout(cmd_t op, logic [ADDR_W-1:0] addr, logic fail,
			logic [TIME_W-1:0] now);
		logic              locked;
		logic              hit;
		logic [TIME_W-1:0] elapsed;
		int unsigned       pos;
		int unsigned       slot;
		locked = 1'b0;
		hit = 1'b0;
		if (op == CMD_CHECK) begin
			for (pos = 0; pos < used && !hit; pos++) begin
				slot = mru[pos];
				if (slot_addr[slot] == addr) begin
					hit = 1'b1;
					elapsed = now - slot_stamp[slot];
					locked = (slot_count[slot] >= limit_q) && (elapsed <= window_q);
					promote(pos);
				end
			end
			if (!hit) begin
				if (used < TABLE_ENTRIES) begin
					pos = used;
					mru[pos] = used;
					used++;
				end else begin
					pos = TABLE_ENTRIES - 1;
				end
				slot = mru[pos];
				slot_addr[slot] = addr;
				slot_count[slot] = '0;
				slot_stamp[slot] = now;
				promote(pos);
			end
		end else if (used > 0) begin
			slot = mru[0];
			if (fail) begin
				if (slot_count[slot] != COUNT_MAX)
					slot_count[slot] = slot_count[slot] + 1'b1;
			end else begin
				slot_count[slot] = '0;
			end
			slot_stamp[slot] = now;
		end
		return locked;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		logic want;
		if (!arst_n) begin
			limit_q = ERROR_LIMIT_RST;
			window_q = LOCKOUT_SECONDS_RST;
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				slot_addr[i] = '0;
				slot_count[i] = '0;
				slot_stamp[i] = '0;
				mru[i] = i;
			end
			used = 0;
			expected_lock.delete();
			requests <= 0;
			responses <= 0;
			mismatches <= 0;
			locked_seen <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_ERROR_LIMIT: begin
						limit_q = cfg_data[COUNT_W-1:0];
					end
					REG_LOCKOUT_SECONDS: begin
						window_q = cfg_data[TIME_W-1:0];
					end
					default: begin
					end
				endcase
			end
			if (out_valid && out_ready) begin
				responses <= responses + 1;
				if (locked_out === 1'b1)
					locked_seen <= locked_seen + 1;
				if (expected_lock.size() == 0) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10)
						$display("unexpected response %0d: locked_out %0b, nothing pending",
							responses, locked_out);
				end else begin
					want = expected_lock.pop_front();
					if (locked_out !== want) begin
						mismatches <= mismatches + 1;
						if (mismatches < 10)
							$display("response %0d: locked_out expected %0b got %0b",
								responses, want, locked_out);
					end
				end
			end
			if (in_valid && in_ready) begin
				expected_lock.push_back(predict_lockout(cmd_t'(cmd), source_addr, failed,
					now_seconds));
				requests <= requests + 1;
			end
		end
	end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps

// Stimulus and verdict for the source lockout table. The checker beside the
// block does all prediction; this module only feeds requests and register
// writes, throttles the response side and reads back the checker's counts at the end.
module tb_top;
	import lslt_pkg::*;

	localparam int unsigned CYCLE_LIMIT     = 500_000;
	localparam int          RANDOM_PHASES   = 6;
	localparam int unsigned ITEMS_PER_PHASE = 125;
	localparam int unsigned HOLD_CYCLES     = 80;
	localparam int          POOL_SIZE       = 6;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	cmd_t                  cmd = CMD_CHECK;
	logic [ADDR_W-1:0]     source_addr = '0;
	logic                  failed = 1'b0;
	logic [TIME_W-1:0]     now_seconds = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic                  locked_out;
	logic                  cfg_we = 1'b0;
	cfg_reg_t              cfg_index = REG_ERROR_LIMIT;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int                    mismatches;
	int                    pending;
	int                    locked_seen;

	// stimulus bookkeeping
	int unsigned           sent = 0;
	int unsigned           responses_taken = 0;
	int unsigned           settings_used = 0;
	int unsigned           cycle_cnt = 0;
	bit                    burst = 1'b0;      // both sides at full rate
	bit                    tx_quiet = 1'b0;   // sender stretch without gaps
	bit                    rx_quiet = 1'b0;   // receiver stretch without stalls
	bit                    rx_holding = 1'b0; // long receiver hold-off in progress
	logic [TIME_W-1:0]     clock_sec = '0;    // running wall clock for requests
	logic [ADDR_W-1:0]     addr_pool [POOL_SIZE];

	lru_source_lockout_table_core u_top (.*);

	lockout_checker u_checker (.*);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// hard stop in case the handshakes hang
	initial begin : watchdog
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("status: fail");
		$finish;
	end

	// Wall clock moves forward by a few seconds per request, sometimes not at all,
	// so both the inclusive window edge and same-second hits come up.
	function automatic logic [TIME_W-1:0] tick();
		clock_sec = clock_sec + $urandom_range(0, 3);
		return clock_sec;
	endfunction

	// One request: optional gap with valid low, then hold valid until in_ready.
	task automatic send_request(cmd_t op, logic [ADDR_W-1:0] addr, logic fail,
			logic [TIME_W-1:0] now);
		int unsigned gap;
		gap = (burst || tx_quiet || rx_holding) ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= op;
		source_addr <= addr;
		failed <= fail;
		now_seconds <= now;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sent++;
		// every 40 requests, maybe switch to a gapless stretch
		if (sent % 40 == 0)
			tx_quiet = ($urandom_range(0, 3) == 0);
	endtask

	// Drop valid and wait for every outstanding response. The checker's counts
	// move on the edge itself, so wait past it before trusting them.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Both registers, back to back; junk in the unused upper bits of the limit
	// write checks that only the low 16 bits land.
	task automatic program_limits(logic [COUNT_W-1:0] limit, logic [TIME_W-1:0] window);
		logic [CFG_DATA_W-COUNT_W-1:0] junk;
		junk = (CFG_DATA_W-COUNT_W)'($urandom);
		cfg_we <= 1'b1;
		cfg_index <= REG_ERROR_LIMIT;
		cfg_data <= {junk, limit};
		@(posedge clk);
		cfg_index <= REG_LOCKOUT_SECONDS;
		cfg_data <= window;
		@(posedge clk);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// Mostly check-then-record sequences on a small address pool so that entries
	// get hit again, build up failures and lock; the rest is lone checks, lone
	// records, random addresses and clock jumps in either direction.
	task automatic run_random(int unsigned count);
		int unsigned       target;
		int unsigned       r;
		int unsigned       nrec;
		logic [ADDR_W-1:0] addr;
		target = sent + count;
		addr_pool[0] = '0;
		addr_pool[1] = '1;
		for (int i = 2; i < POOL_SIZE; i++)
			addr_pool[i] = $urandom;
		while (sent < target) begin
			r = $urandom_range(0, 99);
			addr = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
			if (r < 65) begin
				send_request(CMD_CHECK, addr, 1'($urandom_range(0, 1)), tick());
				nrec = $urandom_range(0, 4);
				repeat (nrec)
					send_request(CMD_RECORD, $urandom, $urandom_range(0, 5) != 0, tick());
				if ($urandom_range(0, 1))
					send_request(CMD_CHECK, addr, 1'($urandom_range(0, 1)), tick());
			end else if (r < 80) begin
				send_request(CMD_CHECK, addr, 1'($urandom_range(0, 1)), tick());
			end else if (r < 92) begin
				send_request(CMD_RECORD, $urandom, 1'($urandom_range(0, 1)), tick());
			end else begin
				clock_sec = $urandom;
				send_request(CMD_CHECK, $urandom, 1'($urandom_range(0, 1)), clock_sec);
			end
		end
	endtask

	// Response side: random stall before each response, gapless stretches, and
	// two long hold-offs so the block backs up and drops in_ready.
	initial begin : response_sink
		int unsigned stall;
		@(posedge arst_n);
		forever begin
			stall = (burst || rx_quiet) ? 0 : $urandom_range(0, 15);
			if (responses_taken == 150 || responses_taken == 500) begin
				rx_holding = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				rx_holding = 1'b0;
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			responses_taken++;
			if (responses_taken % 40 == 0)
				rx_quiet = ($urandom_range(0, 3) == 0);
		end
	end

	initial begin : stimulus
		logic [COUNT_W-1:0] limit;
		logic [TIME_W-1:0]  window;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// ---- directed: limit 2, window 5 ----
		program_limits(16'd2, 32'd5);
		// record before anything is in the table: ignored, answers 0
		send_request(CMD_RECORD, '1, 1'b1, 32'd7);
		// address 0 at time 0, two failures, then probe the window edges
		send_request(CMD_CHECK, '0, 1'b0, 32'd0);
		send_request(CMD_RECORD, '0, 1'b1, 32'd10);
		send_request(CMD_RECORD, '0, 1'b1, 32'd10);
		send_request(CMD_CHECK, '0, 1'b0, 32'd15);  // elapsed equals window: locked
		send_request(CMD_CHECK, '0, 1'b0, 32'd16);  // one past the window
		send_request(CMD_CHECK, '0, 1'b1, 32'd9);   // clock went backward
		// all-ones address, failures stamped just before the time wraps
		send_request(CMD_CHECK, '1, 1'b1, '1);
		send_request(CMD_RECORD, '1, 1'b1, '1);
		send_request(CMD_RECORD, '0, 1'b1, 32'hFFFF_FFFE);
		send_request(CMD_CHECK, '1, 1'b0, 32'd3);   // wraps forward by 5: locked
		// fill the table, then keep missing so the oldest entries get evicted
		send_request(CMD_CHECK, 32'hA5A5_5A5A, 1'b0, 32'h8000_0000);
		send_request(CMD_CHECK, 32'h1234_5678, 1'b1, 32'h8000_0001);
		send_request(CMD_CHECK, '0, 1'b0, 32'd16);
		send_request(CMD_CHECK, '1, 1'b0, 32'd17);
		// failures then a clear on the front entry
		send_request(CMD_CHECK, 32'h1234_5678, 1'b0, 32'd18);
		send_request(CMD_RECORD, 32'h1234_5678, 1'b1, 32'd19);
		send_request(CMD_RECORD, 32'h1234_5678, 1'b1, 32'd19);
		send_request(CMD_RECORD, 32'h1234_5678, 1'b0, 32'd20);
		send_request(CMD_CHECK, 32'h1234_5678, 1'b0, 32'd20);
		drain();

		// ---- directed: limit 0, window 0 ----
		program_limits('0, '0);
		send_request(CMD_CHECK, 32'h1234_5678, 1'b0, 32'd20);  // any count, same second
		send_request(CMD_CHECK, '0, 1'b0, 32'd21);             // past the window
		send_request(CMD_CHECK, 32'h0BAD_F00D, 1'b0, 32'd21);  // miss never locks
		drain();

		// ---- random phases over several register settings ----
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph)
				0: begin
					limit = ERROR_LIMIT_RST;
					window = LOCKOUT_SECONDS_RST;
				end
				1: begin
					limit = 16'd1;
					window = '0;
				end
				2: begin
					limit = 16'd3;
					window = 32'd30;
				end
				3: begin
					limit = COUNT_MAX;
					window = '1;
				end
				4: begin
					limit = 16'd2;
					window = 32'd8;
				end
				default: begin
					limit = COUNT_W'($urandom_range(1, 6));
					window = $urandom_range(0, 60);
				end
			endcase
			program_limits(limit, window);
			run_random(ITEMS_PER_PHASE);
			drain();
		end

		// ---- failures piling up at full rate, then a clear ----
		program_limits(16'd3, 32'd100);
		burst = 1'b1;
		send_request(CMD_CHECK, 32'h5A5A_A5A5, 1'b0, clock_sec);
		repeat (3)
			send_request(CMD_RECORD, $urandom, 1'b1, clock_sec);
		send_request(CMD_CHECK, 32'h5A5A_A5A5, 1'b0, clock_sec);  // at the limit: locked
		send_request(CMD_RECORD, '0, 1'b0, clock_sec);            // clears the count
		send_request(CMD_CHECK, 32'h5A5A_A5A5, 1'b1, clock_sec);
		drain();
		burst = 1'b0;

		$display("covered %0d requests under %0d register settings, %0d answered locked",
			sent, settings_used, locked_seen);
		$display("window edges, wrapped time, eviction, clears and full-rate runs included");
		if (mismatches == 0 && pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/lslt_pkg.sv
rtl/core/lslt_slot.sv
rtl/core/lslt_recency.sv
rtl/core/lru_source_lockout_table_core.sv
rtl/core/lslt_checker.sv
sim/lockout_checker.sv
sim/tb_top.sv
